// ===== src/adam_optimizer_update_defines.svh =====
// Assertion macros shared by the Adam update RTL.
// Needs i_clk and i_rst_n in the scope of the module that uses them.
`ifndef ADAM_OPTIMIZER_UPDATE_DEFINES_SVH
`define ADAM_OPTIMIZER_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define AOU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define AOU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/aou_pkg.sv =====
// Package for the Adam update block: widths, register codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package aou_pkg;

    localparam int AOU_FRAC_BITS  = 24;
    localparam int AOU_WORD_WIDTH = 32;
    localparam int FIELD_W        = 32;
    localparam int VEL_W          = 31;
    localparam int CFG_W          = 24;
    localparam int CFG_IDX_W      = 3;
    // magnitude of learn_rate times a saturated moment
    localparam int MAG_W          = CFG_W + VEL_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARN_RATE = 3'd0,
        CFG_BETA_MOM   = 3'd1,
        CFG_BETA_VEL   = 3'd2,
        CFG_EPSILON    = 3'd3
    } t_cfg_idx;

    // decay factors already clamped to one, their complements, learn rate
    typedef struct packed {
        logic [31:0]      b1;
        logic [31:0]      c1;
        logic [31:0]      b2;
        logic [31:0]      c2;
        logic [CFG_W-1:0] lr;
    } t_coef;

    // element data carried along the cell chains
    typedef struct packed {
        logic signed [FIELD_W-1:0] weight;
        logic                      last;
        logic signed [FIELD_W-1:0] mom;
        logic [VEL_W-1:0]          vel;
        logic [MAG_W-1:0]          mag;
        logic                      neg;
    } t_side;

endpackage

// ===== src/aou_moments.sv =====
// Front stages of the Adam update: new moments and the step numerator.
// Depends on aou_pkg.
`timescale 1ns / 1ps

module aou_moments #(
    parameter int FRAC_BITS  = aou_pkg::AOU_FRAC_BITS,
    parameter int WORD_WIDTH = aou_pkg::AOU_WORD_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [aou_pkg::FIELD_W-1:0] i_grad,
    input  logic signed [aou_pkg::FIELD_W-1:0] i_mom,
    input  logic        [aou_pkg::VEL_W-1:0]   i_vel,
    input  logic signed [aou_pkg::FIELD_W-1:0] i_weight,
    input  logic                               i_last,
    input  aou_pkg::t_coef                     i_coef,
    output logic                               o_valid,
    output aou_pkg::t_side                     o_side
);

    localparam int DW     = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
    localparam int FW     = aou_pkg::FIELD_W;
    localparam int VW     = aou_pkg::VEL_W;
    localparam int PM_W   = FRAC_BITS + 2 + FW;
    localparam int MS_W   = PM_W + 1;
    localparam int PV_W   = FRAC_BITS + 1 + VW;
    localparam int VB_W   = PV_W - FRAC_BITS;
    localparam int G2_W   = 2 * FW - FRAC_BITS;
    localparam int HI_W   = G2_W - VW;
    localparam int PLO_W  = FRAC_BITS + 1 + VW;
    localparam int PHI_W  = FRAC_BITS + 1 + HI_W;
    localparam int VC_W   = PHI_W + VW;
    localparam int VS_W   = VC_W + 1;
    localparam int NUM_W  = aou_pkg::CFG_W + 1 + FW;
    localparam longint SMAX = (longint'(1) << (DW - 1)) - 1;
    localparam longint SMIN = -SMAX - 1;

    // stage 1: captured operands
    logic                 r1_vld;
    logic signed [FW-1:0] r1_g, r1_m, r1_w;
    logic [FW-1:0]        r1_ag;
    logic [VW-1:0]        r1_v;
    logic                 r1_last;
    logic [FW-1:0]        n_ag;

    // stage 2: products
    logic                   r2_vld;
    logic signed [PM_W-1:0] r2_pm1, r2_pc1;
    logic [2*FW-1:0]        r2_pg;
    logic [PV_W-1:0]        r2_pv;
    logic signed [FW-1:0]   r2_w;
    logic                   r2_last;

    // stage 3: new momentum, squared gradient
    logic                   r3_vld;
    logic signed [FW-1:0]   r3_mn, r3_w;
    logic [G2_W-1:0]        r3_g2;
    logic [VB_W-1:0]        r3_vb;
    logic                   r3_last;
    logic signed [MS_W-1:0] mn_sum;
    logic signed [FW-1:0]   n_mn;

    // stage 4: velocity partial products, numerator
    logic                    r4_vld;
    logic [PLO_W-1:0]        r4_plo;
    logic [PHI_W-1:0]        r4_phi;
    logic signed [NUM_W-1:0] r4_num;
    logic [VB_W-1:0]         r4_vb;
    logic signed [FW-1:0]    r4_mn, r4_w;
    logic                    r4_last;

    // stage 5: side data for the root chain
    logic                r5_vld;
    aou_pkg::t_side      r5_side;
    logic [VC_W-1:0]     vc;
    logic [VS_W-1:0]     vs;
    logic [VW-1:0]       n_vn;
    logic [aou_pkg::MAG_W-1:0] n_mag;

    // take the gradient magnitude ahead of the square
    assign n_ag = i_grad[FW-1] ? FW'(-i_grad) : FW'(i_grad);

    // first moment sum and saturation
    always_comb begin
        mn_sum = MS_W'(r2_pm1 >>> FRAC_BITS) + MS_W'(r2_pc1 >>> FRAC_BITS);
        if (mn_sum > SMAX) begin
            n_mn = FW'(SMAX);
        end else if (mn_sum < SMIN) begin
            n_mn = FW'(SMIN);
        end else begin
            n_mn = FW'(mn_sum);
        end
    end

    // second moment sum and saturation, numerator magnitude
    always_comb begin
        vc = (VC_W'({r4_phi, {VW{1'b0}}}) + VC_W'(r4_plo)) >> FRAC_BITS;
        vs = VS_W'(r4_vb) + VS_W'(vc);
        if (vs > VS_W'(SMAX)) begin
            n_vn = VW'(SMAX);
        end else begin
            n_vn = VW'(vs);
        end
        n_mag = r4_num[NUM_W-1] ? aou_pkg::MAG_W'(-r4_num) : aou_pkg::MAG_W'(r4_num);
    end

    // valid bits advance with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    // payload stages, held while stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_g    <= i_grad;
            r1_m    <= i_mom;
            r1_w    <= i_weight;
            r1_ag   <= n_ag;
            r1_v    <= i_vel;
            r1_last <= i_last;

            r2_pm1  <= $signed({1'b0, i_coef.b1[FRAC_BITS:0]}) * r1_m;
            r2_pc1  <= $signed({1'b0, i_coef.c1[FRAC_BITS:0]}) * r1_g;
            r2_pg   <= (2*FW)'(r1_ag) * (2*FW)'(r1_ag);
            r2_pv   <= PV_W'(i_coef.b2[FRAC_BITS:0]) * PV_W'(r1_v);
            r2_w    <= r1_w;
            r2_last <= r1_last;

            r3_mn   <= n_mn;
            r3_g2   <= G2_W'(r2_pg >> FRAC_BITS);
            r3_vb   <= VB_W'(r2_pv >> FRAC_BITS);
            r3_w    <= r2_w;
            r3_last <= r2_last;

            r4_plo  <= PLO_W'(i_coef.c2[FRAC_BITS:0]) * PLO_W'(r3_g2[VW-1:0]);
            r4_phi  <= PHI_W'(i_coef.c2[FRAC_BITS:0]) * PHI_W'(r3_g2[G2_W-1:VW]);
            r4_num  <= $signed({1'b0, i_coef.lr}) * r3_mn;
            r4_vb   <= r3_vb;
            r4_mn   <= r3_mn;
            r4_w    <= r3_w;
            r4_last <= r3_last;

            r5_side.weight <= r4_w;
            r5_side.last   <= r4_last;
            r5_side.mom    <= r4_mn;
            r5_side.vel    <= n_vn;
            r5_side.mag    <= n_mag;
            r5_side.neg    <= r4_num[NUM_W-1];
        end
    end

    assign o_valid = r5_vld;
    assign o_side  = r5_side;

endmodule

// ===== src/aou_sqrt_cell.sv =====
// Integer square root cell: settles one root bit per cycle while enabled.
// Depends on aou_pkg.
`timescale 1ns / 1ps

module aou_sqrt_cell #(
    parameter int RB = 28
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  aou_pkg::t_side      i_side,
    input  logic [2*RB-1:0]     i_x,
    input  logic [RB+2:0]       i_rem,
    input  logic [RB-1:0]       i_root,
    output logic                o_valid,
    output aou_pkg::t_side      o_side,
    output logic [2*RB-1:0]     o_x,
    output logic [RB+2:0]       o_rem,
    output logic [RB-1:0]       o_root
);

    logic                r_vld;
    aou_pkg::t_side      r_side;
    logic [2*RB-1:0]     r_x;
    logic [RB+2:0]       r_rem;
    logic [RB-1:0]       r_root;
    logic [RB+2:0]       cur, trial, n_rem;
    logic                ge;

    // bring down the next bit pair and try the next root bit
    always_comb begin
        cur   = {i_rem[RB:0], i_x[2*RB-1 -: 2]};
        trial = (RB+3)'({i_root, 2'b01});
        ge    = (cur >= trial);
        n_rem = ge ? cur - trial : cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_x    <= {i_x[2*RB-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= {i_root[RB-2:0], ge};
        end
    end

    assign o_valid = r_vld;
    assign o_side  = r_side;
    assign o_x     = r_x;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

// ===== src/aou_div_cell.sv =====
// Restoring divider cell: settles one quotient bit per cycle while enabled.
// Depends on aou_pkg.
`timescale 1ns / 1ps

module aou_div_cell #(
    parameter int DEN_W = 29
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  aou_pkg::t_side              i_side,
    input  logic [DEN_W-1:0]            i_den,
    input  logic [DEN_W-1:0]            i_rem,
    input  logic [aou_pkg::MAG_W-1:0]   i_acc,
    output logic                        o_valid,
    output aou_pkg::t_side              o_side,
    output logic [DEN_W-1:0]            o_den,
    output logic [DEN_W-1:0]            o_rem,
    output logic [aou_pkg::MAG_W-1:0]   o_acc
);

    localparam int MW = aou_pkg::MAG_W;

    logic                r_vld;
    aou_pkg::t_side      r_side;
    logic [DEN_W-1:0]    r_den, r_rem;
    logic [MW-1:0]       r_acc;
    logic [DEN_W:0]      cur;
    logic                ge;
    logic [DEN_W-1:0]    n_rem;

    // shift in the next dividend bit and subtract where it fits
    always_comb begin
        cur   = {i_rem, i_acc[MW-1]};
        ge    = (cur >= {1'b0, i_den});
        n_rem = ge ? DEN_W'(cur - {1'b0, i_den}) : DEN_W'(cur);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_den  <= i_den;
            r_rem  <= n_rem;
            r_acc  <= {i_acc[MW-2:0], ge};
        end
    end

    assign o_valid = r_vld;
    assign o_side  = r_side;
    assign o_den   = r_den;
    assign o_rem   = r_rem;
    assign o_acc   = r_acc;

endmodule

// ===== src/adam_optimizer_update.sv =====
// Adam update of one element per transaction, fully pipelined.
// Stages: 5 front stages + RB root cells + 1 divisor stage + 55 divider cells + 1 output
// stage, RB = ceil((min(WORD_WIDTH,32)-1+FRAC_BITS)/2).
// Throughput: one element per cycle unless the output stalls, set by the root and
// divider cell chains. A stalled output freezes every stage; reset clears all valid
// bits and loads the register defaults.
// Depends on aou_pkg, aou_moments, aou_sqrt_cell, aou_div_cell and the defines header.
`timescale 1ns / 1ps
`include "adam_optimizer_update_defines.svh"

module adam_optimizer_update #(
    parameter int FRAC_BITS  = aou_pkg::AOU_FRAC_BITS,
    parameter int WORD_WIDTH = aou_pkg::AOU_WORD_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [aou_pkg::FIELD_W-1:0]   i_grad,
    input  logic signed [aou_pkg::FIELD_W-1:0]   i_mom_in,
    input  logic        [aou_pkg::VEL_W-1:0]     i_vel_in,
    input  logic signed [aou_pkg::FIELD_W-1:0]   i_weight_in,
    input  logic                                 i_last_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [aou_pkg::FIELD_W-1:0]   o_mom_out,
    output logic        [aou_pkg::VEL_W-1:0]     o_vel_out,
    output logic signed [aou_pkg::FIELD_W-1:0]   o_weight_out,
    output logic                                 o_last_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [aou_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [aou_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int DW    = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
    localparam int CW    = aou_pkg::CFG_W;
    localparam int FW    = aou_pkg::FIELD_W;
    localparam int MW    = aou_pkg::MAG_W;
    localparam int XW    = DW - 1 + FRAC_BITS;
    localparam int RB    = (XW + 1) / 2;
    localparam int XPW   = 2 * RB;
    localparam int DEN_W = ((RB > CW) ? RB : CW) + 1;
    localparam int QN    = MW;
    localparam int WS_W  = MW + 2;
    localparam longint SMAX = (longint'(1) << (DW - 1)) - 1;
    localparam longint SMIN = -SMAX - 1;
    localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

    // configuration registers
    logic [CW-1:0]    r_learn_rate, r_beta_mom, r_beta_vel, r_epsilon;
    aou_pkg::t_coef   r_coef;
    logic [31:0]      bm_ext, bv_ext, b1, b2;
    logic [CW-1:0]    eps;

    // pipeline control
    logic             adv;

    // chains
    logic                 fr_vld;
    aou_pkg::t_side       fr_side;
    logic                 sq_vld  [0:RB];
    aou_pkg::t_side       sq_side [0:RB];
    logic [XPW-1:0]       sq_x    [0:RB];
    logic [RB+2:0]        sq_rem  [0:RB];
    logic [RB-1:0]        sq_root [0:RB];
    logic                 r_den_vld;
    aou_pkg::t_side       r_den_side;
    logic [DEN_W-1:0]     r_den;
    logic                 dv_vld  [0:QN];
    aou_pkg::t_side       dv_side [0:QN];
    logic [DEN_W-1:0]     dv_den  [0:QN];
    logic [DEN_W-1:0]     dv_rem  [0:QN];
    logic [MW-1:0]        dv_acc  [0:QN];

    // output stage
    logic                   r_out_vld;
    aou_pkg::t_side         r_out_side;
    logic signed [FW-1:0]   r_out_weight;
    logic signed [MW:0]     step;
    logic signed [WS_W-1:0] wsum;
    logic signed [FW-1:0]   n_weight;

    // advance everything unless a result is waiting and not taken
    assign adv         = !r_out_vld || i_out_ready;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate <= CW'(16777);
            r_beta_mom   <= CW'(15099494);
            r_beta_vel   <= CW'(16760439);
            r_epsilon    <= CW'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                aou_pkg::CFG_LEARN_RATE: r_learn_rate <= i_cfg_data;
                aou_pkg::CFG_BETA_MOM:   r_beta_mom   <= i_cfg_data;
                aou_pkg::CFG_BETA_VEL:   r_beta_vel   <= i_cfg_data;
                aou_pkg::CFG_EPSILON:    r_epsilon    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp decays to one, force a zero epsilon to one, form the complements
    always_comb begin
        bm_ext = 32'(r_beta_mom);
        bv_ext = 32'(r_beta_vel);
        b1     = (bm_ext > ONE_Q) ? ONE_Q : bm_ext;
        b2     = (bv_ext > ONE_Q) ? ONE_Q : bv_ext;
        eps    = (r_epsilon == '0) ? CW'(1) : r_epsilon;
    end

    always_ff @(posedge i_clk) begin
        r_coef.b1 <= b1;
        r_coef.c1 <= ONE_Q - b1;
        r_coef.b2 <= b2;
        r_coef.c2 <= ONE_Q - b2;
        r_coef.lr <= r_learn_rate;
    end

    // moments and numerator
    aou_moments #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_moments (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_valid  (i_in_valid),
        .i_grad   (i_grad),
        .i_mom    (i_mom_in),
        .i_vel    (i_vel_in),
        .i_weight (i_weight_in),
        .i_last   (i_last_in),
        .i_coef   (r_coef),
        .o_valid  (fr_vld),
        .o_side   (fr_side)
    );

    // feed the root chain with v' scaled by one
    assign sq_vld[0]  = fr_vld;
    assign sq_side[0] = fr_side;
    assign sq_x[0]    = XPW'(fr_side.vel[DW-2:0]) << FRAC_BITS;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        aou_sqrt_cell #(
            .RB (RB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (sq_vld[k]),
            .i_side  (sq_side[k]),
            .i_x     (sq_x[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .o_valid (sq_vld[k+1]),
            .o_side  (sq_side[k+1]),
            .o_x     (sq_x[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1])
        );
    end

    // form the divisor: root plus epsilon
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_den_vld <= 1'b0;
        end else if (adv) begin
            r_den_vld <= sq_vld[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_den_side <= sq_side[RB];
            r_den      <= DEN_W'(sq_root[RB]) + DEN_W'(eps);
        end
    end

    assign dv_vld[0]  = r_den_vld;
    assign dv_side[0] = r_den_side;
    assign dv_den[0]  = r_den;
    assign dv_rem[0]  = '0;
    assign dv_acc[0]  = r_den_side.mag;

    for (genvar k = 0; k < QN; k++) begin : g_div
        aou_div_cell #(
            .DEN_W (DEN_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (dv_vld[k]),
            .i_side  (dv_side[k]),
            .i_den   (dv_den[k]),
            .i_rem   (dv_rem[k]),
            .i_acc   (dv_acc[k]),
            .o_valid (dv_vld[k+1]),
            .o_side  (dv_side[k+1]),
            .o_den   (dv_den[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_acc   (dv_acc[k+1])
        );
    end

    // apply the signed step and saturate the weight
    always_comb begin
        step = dv_side[QN].neg ? -$signed({1'b0, dv_acc[QN]}) : $signed({1'b0, dv_acc[QN]});
        wsum = WS_W'(dv_side[QN].weight) + WS_W'(step);
        if (wsum > SMAX) begin
            n_weight = FW'(SMAX);
        end else if (wsum < SMIN) begin
            n_weight = FW'(SMIN);
        end else begin
            n_weight = FW'(wsum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= dv_vld[QN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_side   <= dv_side[QN];
            r_out_weight <= n_weight;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_mom_out    = r_out_side.mom;
    assign o_vel_out    = r_out_side.vel;
    assign o_weight_out = r_out_weight;
    assign o_last_out   = r_out_side.last;

    // checks
    `AOU_ASSERT_NXT(a_out_drains, r_out_vld && i_out_ready && !dv_vld[QN], !r_out_vld, "output valid without a transaction behind it")
    `AOU_ASSERT_IMP(a_vel_range, r_out_vld, longint'(o_vel_out) <= SMAX, "velocity above saturation bound")
    `AOU_ASSERT_IMP(a_den_nonzero, r_den_vld, r_den != '0, "zero divisor entered the divider")
    `AOU_ASSERT_NXT(a_eps_write, i_cfg_valid && i_cfg_index == aou_pkg::CFG_EPSILON, r_epsilon == $past(i_cfg_data), "epsilon write lost")

endmodule
